[hdl/dfb1_pkg.sv]
// Shared types and constants for the DREAM flip angle / B1 map block.
// Holds the item structs, the CORDIC arctangent table and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dfb1_pkg;

  localparam int FIELD_W      = 16;
  localparam int NOM_W        = 16;
  localparam int CORDIC_STEPS = 20;
  localparam int Z_FRAC       = 24;
  localparam int SQRT_OPW     = 64;
  localparam int ROOT_W       = SQRT_OPW / 2;
  localparam int DIV_NW       = 25;
  localparam logic [FIELD_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] fid_signal;
    logic [FIELD_W-1:0] ste_signal;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] flip_angle;
    logic [FIELD_W-1:0] b1_ratio;
    logic               zero_fid;
  } out_item_t;

  // atan(2^-i) in degrees, Q7.24
  function automatic logic [31:0] atan_deg(input int i);
    logic [31:0] v;
    begin
      case (i)
        0:  v = 32'd754974720;
        1:  v = 32'd445687602;
        2:  v = 32'd235489088;
        3:  v = 32'd119537938;
        4:  v = 32'd60000934;
        5:  v = 32'd30029717;
        6:  v = 32'd15018523;
        7:  v = 32'd7509720;
        8:  v = 32'd3754917;
        9:  v = 32'd1877466;
        10: v = 32'd938734;
        11: v = 32'd469367;
        12: v = 32'd234684;
        13: v = 32'd117342;
        14: v = 32'd58671;
        15: v = 32'd29335;
        16: v = 32'd14668;
        17: v = 32'd7334;
        18: v = 32'd3667;
        19: v = 32'd1833;
        default: v = 32'd0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

[hdl/dream_flip_angle_b1_map.sv]
// DREAM B1 map top level: flip angle and B1 ratio per voxel.
// Depends on dfb1_pkg, dfb1_isqrt_pipe and dfb1_div_pipe.
`timescale 1ns / 1ps
`default_nettype none
// One voxel (FID, STE) enters per clock; busy is always low, so start may be
// pulsed every cycle. Each voxel leaves through these stages as a single
// out_valid strobe, in order: 1 input register, 32 square-root stages (one
// root bit each), 20 CORDIC vectoring stages, 1 rounding stage, 25 divider
// stages (one quotient bit each) and 1 output register. The receiver cannot
// stall, so nothing is held back. The angle is atan2(sqrt(2*STE), sqrt(FID))
// in degrees, Q7.9; the ratio is angle*256/nominal, rounded and saturated at
// 90.0. Write cfg_wdata (nominal angle, Q8.8) only with the pipeline empty.
module dream_flip_angle_b1_map #(
  parameter int SAMPLE_BITS     = 16,
  parameter int ANGLE_FRAC_BITS = 9
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dfb1_pkg::in_item_t  in_data,
  output logic                     out_valid,
  output dfb1_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata
);
  import dfb1_pkg::*;

  localparam int SH      = 62 - SAMPLE_BITS;
  localparam int DROP    = Z_FRAC - ANGLE_FRAC_BITS;
  localparam int CXW     = ROOT_W + 4;
  localparam int ZW      = 34;
  localparam int LATENCY = 1 + ROOT_W + CORDIC_STEPS + 1 + DIV_NW + 1;
  localparam logic [63:0] SMASK    = (64'd1 << SAMPLE_BITS) - 64'd1;
  localparam logic [31:0] FULL     = 32'd90 << ANGLE_FRAC_BITS;
  localparam logic [31:0] Z_MAX    = 32'd90 << Z_FRAC;
  localparam logic [31:0] RND      = 32'd1 << (DROP - 1);
  localparam logic [FIELD_W-1:0] SAT =
    (FULL > 32'(OUT_MAX)) ? OUT_MAX : FULL[FIELD_W-1:0];

  // nothing ever blocks the pipeline
  assign busy = 1'b0;

  // configuration register
  logic [NOM_W-1:0] nom_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r <= NOM_W'(14080);
    end else if (cfg_we) begin
      nom_r <= cfg_wdata;
    end
  end

  // input register: mask samples, note the special cases, prescale operands
  logic        s0_v_r;
  logic [63:0] s0_fid_r, s0_ste_r;
  logic [1:0]  s0_flag_r;
  logic [63:0] fid_nxt, ste_nxt;

  always_comb begin
    fid_nxt = 64'(in_data.fid_signal) & SMASK;
    ste_nxt = 64'(in_data.ste_signal) & SMASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start & ~busy;
    end
    s0_fid_r  <= fid_nxt << SH;
    s0_ste_r  <= (ste_nxt << 1) << SH;
    // flag[1]: FID is zero, flag[0]: STE is zero
    s0_flag_r <= {fid_nxt == 64'd0, ste_nxt == 64'd0};
  end

  // square roots of both operands
  logic              sq_v;
  logic [ROOT_W-1:0] sq_x, sq_y;
  logic [1:0]        sq_flag;

  dfb1_isqrt_pipe #(.OPW(SQRT_OPW), .TAGW(2)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s0_v_r),
    .in_op_a   (s0_fid_r),
    .in_op_b   (s0_ste_r),
    .in_tag    (s0_flag_r),
    .out_valid (sq_v),
    .out_root_a(sq_x),
    .out_root_b(sq_y),
    .out_tag   (sq_flag)
  );

  // CORDIC vectoring: drive y to zero, accumulate the angle in z
  logic                  cv    [CORDIC_STEPS+1];
  logic [1:0]            cflag [CORDIC_STEPS+1];
  logic signed [CXW-1:0] cx    [CORDIC_STEPS+1];
  logic signed [CXW-1:0] cy    [CORDIC_STEPS+1];
  logic signed [ZW-1:0]  cz    [CORDIC_STEPS+1];

  assign cv[0]    = sq_v;
  assign cflag[0] = sq_flag;
  assign cx[0]    = $signed(CXW'(sq_x));
  assign cy[0]    = $signed(CXW'(sq_y));
  assign cz[0]    = '0;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    logic                  v_r;
    logic [1:0]            flag_r;
    logic signed [CXW-1:0] x_r, y_r, x_nxt, y_nxt;
    logic signed [ZW-1:0]  z_r, z_nxt;
    logic signed [ZW-1:0]  step_ang;

    always_comb begin
      step_ang = $signed(ZW'(atan_deg(g)));
      // arithmetic shift floors toward minus infinity
      if (cy[g] > 0) begin
        x_nxt = cx[g] + (cy[g] >>> g);
        y_nxt = cy[g] - (cx[g] >>> g);
        z_nxt = cz[g] + step_ang;
      end else begin
        x_nxt = cx[g] - (cy[g] >>> g);
        y_nxt = cy[g] + (cx[g] >>> g);
        z_nxt = cz[g] - step_ang;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else begin
        v_r <= cv[g];
      end
      flag_r <= cflag[g];
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end

    assign cv[g+1]    = v_r;
    assign cflag[g+1] = flag_r;
    assign cx[g+1]    = x_r;
    assign cy[g+1]    = y_r;
    assign cz[g+1]    = z_r;
  end

  // round stage: clamp, round half up, apply special cases, build dividend
  logic                 rd_v_r;
  logic                 rd_fidz_r;
  logic [FIELD_W-1:0]   rd_ang_r;
  logic [DIV_NW-1:0]    rd_num_r;
  logic [31:0]          zc, zr;
  logic [FIELD_W-1:0]   ang_nxt;
  logic [1:0]           fl;
  logic signed [ZW-1:0] zf;

  always_comb begin
    zf = cz[CORDIC_STEPS];
    fl = cflag[CORDIC_STEPS];
    if (zf < 0) begin
      zc = 32'd0;
    end else if (zf > $signed(ZW'(Z_MAX))) begin
      zc = Z_MAX;
    end else begin
      zc = zf[31:0];
    end
    zr = (zc + RND) >> DROP;
    if (zr > FULL) begin
      zr = FULL;
    end
    if (fl[1]) begin
      zr = fl[0] ? 32'd0 : FULL;
    end else if (fl[0]) begin
      zr = 32'd0;
    end
    ang_nxt = (zr > 32'(OUT_MAX)) ? OUT_MAX : zr[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cv[CORDIC_STEPS];
    end
    rd_fidz_r <= fl[1];
    rd_ang_r  <= ang_nxt;
    rd_num_r  <= {1'b0, ang_nxt, 8'd0} + DIV_NW'(nom_r >> 1);
  end

  // ratio divider; angle and flag ride along as the tag
  logic                 dv_v;
  logic [DIV_NW-1:0]    dv_quo;
  logic [FIELD_W:0]     dv_tag;

  dfb1_div_pipe #(.NW(DIV_NW), .DW(NOM_W), .TAGW(FIELD_W + 1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_v_r),
    .in_num   (rd_num_r),
    .in_den   (nom_r),
    .in_tag   ({rd_ang_r, rd_fidz_r}),
    .out_valid(dv_v),
    .out_quo  (dv_quo),
    .out_tag  (dv_tag)
  );

  // output register: saturate the ratio, zero nominal saturates too
  logic      out_v_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_v;
    end
    out_r.flip_angle <= dv_tag[FIELD_W:1];
    out_r.zero_fid   <= dv_tag[0];
    out_r.b1_ratio   <= ((nom_r == '0) || (dv_quo > DIV_NW'(SAT))) ?
                        SAT : dv_quo[FIELD_W-1:0];
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // each result traces back to exactly one transfer, a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a matching transfer");

  a_zero_fid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_fid) |->
      (out_data.flip_angle == '0 || out_data.flip_angle == SAT))
    else $error("zero FID angle not 0 or 90");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.flip_angle <= SAT && out_data.b1_ratio <= SAT))
    else $error("result out of range");

endmodule
`default_nettype wire

[hdl/dfb1_isqrt_pipe.sv]
// Two-lane pipelined integer square root, one result bit per stage.
// Standalone; carries a side tag alongside the operands.
`timescale 1ns / 1ps
`default_nettype none
module dfb1_isqrt_pipe #(
  parameter int OPW  = 64,
  parameter int TAGW = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [OPW-1:0]      in_op_a,
  input  wire logic [OPW-1:0]      in_op_b,
  input  wire logic [TAGW-1:0]     in_tag,
  output logic                     out_valid,
  output logic [OPW/2-1:0]         out_root_a,
  output logic [OPW/2-1:0]         out_root_b,
  output logic [TAGW-1:0]          out_tag
);
  localparam int STEPS = OPW / 2;
  localparam int RTW   = STEPS;
  localparam int RW    = RTW + 3;

  logic                       v_r   [STEPS];
  logic [TAGW-1:0]            tag_r [STEPS];
  logic [1:0][OPW-1:0]        op_r  [STEPS];
  logic [1:0][RW-1:0]         rem_r [STEPS];
  logic [1:0][RTW-1:0]        root_r[STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= (g == 0) ? in_valid : v_r[(g == 0) ? 0 : g-1];
      end
      tag_r[g] <= (g == 0) ? in_tag : tag_r[(g == 0) ? 0 : g-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [OPW-1:0] op_p, op_nxt;
      logic [RW-1:0]  rem_p, remsh, trial, rem_nxt;
      logic [RTW-1:0] root_p, root_nxt;
      logic           ge;

      if (g == 0) begin : g_first
        assign op_p   = (l == 0) ? in_op_a : in_op_b;
        assign rem_p  = '0;
        assign root_p = '0;
      end else begin : g_rest
        assign op_p   = op_r[g-1][l];
        assign rem_p  = rem_r[g-1][l];
        assign root_p = root_r[g-1][l];
      end

      always_comb begin
        remsh    = {rem_p[RW-3:0], op_p[OPW-1 -: 2]};
        trial    = {1'b0, root_p, 2'b01};
        ge       = (remsh >= trial);
        rem_nxt  = ge ? (remsh - trial) : remsh;
        root_nxt = {root_p[RTW-2:0], ge};
        op_nxt   = {op_p[OPW-3:0], 2'b00};
      end

      always_ff @(posedge clk) begin
        op_r[g][l]   <= op_nxt;
        rem_r[g][l]  <= rem_nxt;
        root_r[g][l] <= root_nxt;
      end
    end
  end

  assign out_valid  = v_r[STEPS-1];
  assign out_tag    = tag_r[STEPS-1];
  assign out_root_a = root_r[STEPS-1][0];
  assign out_root_b = root_r[STEPS-1][1];
endmodule
`default_nettype wire

[hdl/dfb1_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; the divisor must hold while items are in flight.
`timescale 1ns / 1ps
`default_nettype none
module dfb1_div_pipe #(
  parameter int NW   = 25,
  parameter int DW   = 16,
  parameter int TAGW = 17
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [NW-1:0]   in_num,
  input  wire logic [DW-1:0]   in_den,
  input  wire logic [TAGW-1:0] in_tag,
  output logic                 out_valid,
  output logic [NW-1:0]        out_quo,
  output logic [TAGW-1:0]      out_tag
);
  logic            v_r   [NW];
  logic [TAGW-1:0] tag_r [NW];
  logic [NW-1:0]   num_r [NW];
  logic [NW-1:0]   quo_r [NW];
  logic [DW:0]     rem_r [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [NW-1:0] num_p, quo_p, num_nxt, quo_nxt;
    logic [DW:0]   rem_p, remsh, rem_nxt;
    logic          ge;

    if (g == 0) begin : g_first
      assign num_p = in_num;
      assign quo_p = '0;
      assign rem_p = '0;
    end else begin : g_rest
      assign num_p = num_r[g-1];
      assign quo_p = quo_r[g-1];
      assign rem_p = rem_r[g-1];
    end

    always_comb begin
      remsh   = {rem_p[DW-1:0], num_p[NW-1]};
      ge      = (remsh >= {1'b0, in_den});
      rem_nxt = ge ? (remsh - {1'b0, in_den}) : remsh;
      quo_nxt = {quo_p[NW-2:0], ge};
      num_nxt = {num_p[NW-2:0], 1'b0};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= (g == 0) ? in_valid : v_r[(g == 0) ? 0 : g-1];
      end
      tag_r[g] <= (g == 0) ? in_tag : tag_r[(g == 0) ? 0 : g-1];
      num_r[g] <= num_nxt;
      quo_r[g] <= quo_nxt;
      rem_r[g] <= rem_nxt;
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = quo_r[NW-1];
  assign out_tag   = tag_r[NW-1];
endmodule
`default_nettype wire
